>>> rtl/mixed_radix_date_split_core_assert.svh
// Assertion macros used by the date split RTL
`ifndef MIXED_RADIX_DATE_SPLIT_CORE_ASSERT_SVH
`define MIXED_RADIX_DATE_SPLIT_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset
`define MRDS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("date split assertion failed");

// Next-cycle implication, held off during reset
`define MRDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("date split assertion failed");

`endif

>>> rtl/mrds_pkg.sv
// Types and constants of the date split block
package mrds_pkg;

    localparam int unsigned IN_W     = 32;
    localparam int unsigned DAY_W    = 10;
    localparam int unsigned UNIT_W   = 8;
    localparam int unsigned OUT_TD_W = 40;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned SH_W     = 2 * UNIT_W;
    localparam int unsigned SD_W     = 3 * UNIT_W;
    localparam int unsigned SY_W     = SD_W + DAY_W;

    // Stage plan: three lead-in stages, then one restoring step per stage
    localparam int unsigned PRE_N   = 3;
    localparam int unsigned YEAR_0  = PRE_N;
    localparam int unsigned DAY_0   = YEAR_0 + IN_W;
    localparam int unsigned HOUR_0  = DAY_0 + DAY_W;
    localparam int unsigned MIN_0   = HOUR_0 + UNIT_W;
    localparam int unsigned LAST    = MIN_0 + UNIT_W - 1;

    localparam logic [UNIT_W-1:0] RST_SPM = 8'd60;
    localparam logic [UNIT_W-1:0] RST_MPH = 8'd60;
    localparam logic [UNIT_W-1:0] RST_HPD = 8'd24;
    localparam logic [DAY_W-1:0]  RST_DPY = 10'd365;
    localparam logic [SH_W-1:0]   RST_SEC_HOUR = 16'd3600;
    localparam logic [SD_W-1:0]   RST_SEC_DAY  = 24'd86400;
    localparam logic [SY_W-1:0]   RST_SEC_YEAR = 34'd31536000;

    typedef enum logic [1:0] {
        REG_SPM = 2'd0,
        REG_MPH = 2'd1,
        REG_HPD = 2'd2,
        REG_DPY = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [IN_W-1:0]   num;
        logic [IN_W-1:0]   rem;
        logic [DAY_W-1:0]  day;
        logic [UNIT_W-1:0] hour;
        logic [UNIT_W-1:0] minute;
    } t_stage;

endpackage

>>> rtl/mixed_radix_date_split_core.sv
// Pipelined split of elapsed seconds into day, hour, minute and second
//
// Use: elapsed seconds enter on the s_axis group (tdata = 32-bit count), one
// request per cycle. Each yields one result on m_axis: day of year, hour,
// minute and second of minute. Unit lengths come from four APB registers
// (seconds/minute at 0x0, minutes/hour 0x4, hours/day 0x8, days/year 0xC);
// a zero register acts as 1. Write them only while the block is empty.
// There are 61 register stages; throughput is one request per cycle while
// the output is not stalled, set by the single-bit restoring divider stages
// (32 for the year remainder, 10 day, 8 hour, 8 minute bits).
// The unit-length products are registered in a three-deep chain, which the
// three lead-in stages cover.
// Reset clears all valid bits and loads 60/60/24/365; no clearing pass.
// When the receiver stalls the whole pipe holds; a one-entry skid buffer
// takes the request accepted in that cycle and s_axis tready is registered.
module mixed_radix_date_split_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // s_axis_tdata: [31:0] elapsed_seconds
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [mrds_pkg::IN_W-1:0]     i_s_axis_tdata,
    // m_axis_tdata: [9:0] day_of_year, [17:10] hour_of_day,
    // [25:18] minute_of_hour, [33:26] second_of_minute, [39:34] zero
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [mrds_pkg::OUT_TD_W-1:0] o_m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrds_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import mrds_pkg::*;

    logic [UNIT_W-1:0] r_spm, r_mph, r_hpd;
    logic [DAY_W-1:0]  r_dpy;
    logic [UNIT_W-1:0] w_spm, w_mph, w_hpd;
    logic [DAY_W-1:0]  w_dpy;
    logic [SH_W-1:0]   r_sec_hour;
    logic [SD_W-1:0]   r_sec_day;
    logic [SY_W-1:0]   r_sec_year;

    logic              w_adv;
    logic              w_s_acc;
    logic              w_src_vld;
    logic [IN_W-1:0]   w_src;
    logic              r_skid_vld;
    logic [IN_W-1:0]   r_skid;
    logic [LAST:0]     r_vld;
    t_stage            r_pipe [LAST+1];
    t_stage            n_pipe [LAST+1];

    // Register writes and reads
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm <= RST_SPM;
            r_mph <= RST_MPH;
            r_hpd <= RST_HPD;
            r_dpy <= RST_DPY;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_SPM: r_spm <= pwdata[UNIT_W-1:0];
                REG_MPH: r_mph <= pwdata[UNIT_W-1:0];
                REG_HPD: r_hpd <= pwdata[UNIT_W-1:0];
                REG_DPY: r_dpy <= pwdata[DAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_SPM: prdata = {24'd0, r_spm};
            REG_MPH: prdata = {24'd0, r_mph};
            REG_HPD: prdata = {24'd0, r_hpd};
            REG_DPY: prdata = {22'd0, r_dpy};
            default: prdata = 32'd0;
        endcase
    end

    // Treat a zero length as one
    assign w_spm = (r_spm == '0) ? UNIT_W'(1) : r_spm;
    assign w_mph = (r_mph == '0) ? UNIT_W'(1) : r_mph;
    assign w_hpd = (r_hpd == '0) ? UNIT_W'(1) : r_hpd;
    assign w_dpy = (r_dpy == '0) ? DAY_W'(1) : r_dpy;

    // Form the hour, day and year lengths, one multiply per register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_hour <= RST_SEC_HOUR;
            r_sec_day  <= RST_SEC_DAY;
            r_sec_year <= RST_SEC_YEAR;
        end else begin
            r_sec_hour <= w_spm * w_mph;
            r_sec_day  <= r_sec_hour * w_hpd;
            r_sec_year <= r_sec_day * w_dpy;
        end
    end

    // Input skid buffer
    assign w_adv           = !r_vld[LAST] || i_m_axis_tready;
    assign o_s_axis_tready = !r_skid_vld;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_src_vld       = r_skid_vld || w_s_acc;
    assign w_src           = r_skid_vld ? r_skid : i_s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld && w_adv) begin
            r_skid_vld <= 1'b0;
        end else if (w_s_acc && !w_adv) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc && !w_adv) begin
            r_skid <= i_s_axis_tdata;
        end
    end

    // One restoring step of the year remainder: shift in a dividend bit
    function automatic t_stage f_year_step(t_stage s, logic [SY_W-1:0] d);
        logic [IN_W:0] tmp;
        t_stage        o;
        o     = s;
        tmp   = {s.rem, s.num[IN_W-1]};
        o.num = {s.num[IN_W-2:0], 1'b0};
        if ({1'b0, tmp} >= d) begin
            o.rem = IN_W'({1'b0, tmp} - d);
        end else begin
            o.rem = tmp[IN_W-1:0];
        end
        return o;
    endfunction

    // One restoring step against a pre-shifted divisor: {hit, new remainder}
    function automatic logic [IN_W:0] f_sub_step(logic [IN_W-1:0] rem, logic [IN_W:0] d);
        logic hit;
        hit = ({1'b0, rem} >= d);
        return hit ? {1'b1, IN_W'({1'b0, rem} - d)} : {1'b0, rem};
    endfunction

    // Load the entry stage
    always_comb begin
        n_pipe[0]     = '0;
        n_pipe[0].num = w_src;
    end

    // Stage logic: lead-in copies, year remainder steps, then quotient bits
    for (genvar j = 1; j <= LAST; j++) begin : g_stage
        if (j < YEAR_0) begin : g_pre
            assign n_pipe[j] = r_pipe[j-1];
        end else if (j < DAY_0) begin : g_year
            assign n_pipe[j] = f_year_step(r_pipe[j-1], r_sec_year);
        end else if (j < HOUR_0) begin : g_day
            localparam int unsigned K = DAY_0 + DAY_W - 1 - j;
            logic [IN_W:0] w_r;
            assign w_r = f_sub_step(r_pipe[j-1].rem, (IN_W+1)'(r_sec_day) << K);
            always_comb begin
                n_pipe[j]        = r_pipe[j-1];
                n_pipe[j].rem    = w_r[IN_W-1:0];
                n_pipe[j].day[K] = w_r[IN_W];
            end
        end else if (j < MIN_0) begin : g_hour
            localparam int unsigned K = HOUR_0 + UNIT_W - 1 - j;
            logic [IN_W:0] w_r;
            assign w_r = f_sub_step(r_pipe[j-1].rem, (IN_W+1)'(r_sec_hour) << K);
            always_comb begin
                n_pipe[j]         = r_pipe[j-1];
                n_pipe[j].rem     = w_r[IN_W-1:0];
                n_pipe[j].hour[K] = w_r[IN_W];
            end
        end else begin : g_min
            localparam int unsigned K = MIN_0 + UNIT_W - 1 - j;
            logic [IN_W:0] w_r;
            assign w_r = f_sub_step(r_pipe[j-1].rem, (IN_W+1)'(w_spm) << K);
            always_comb begin
                n_pipe[j]           = r_pipe[j-1];
                n_pipe[j].rem       = w_r[IN_W-1:0];
                n_pipe[j].minute[K] = w_r[IN_W];
            end
        end
    end

    // Advance the whole pipe unless the output is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAST-1:0], w_src_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pipe <= n_pipe;
        end
    end

    // Drive the result
    assign o_m_axis_tvalid = r_vld[LAST];
    assign o_m_axis_tdata  = {6'd0, r_pipe[LAST].rem[UNIT_W-1:0], r_pipe[LAST].minute,
                              r_pipe[LAST].hour, r_pipe[LAST].day};

    `include "mixed_radix_date_split_core_assert.svh"

    `MRDS_ASSERT_NEXT(a_skid_drains, r_skid_vld && w_adv, !r_skid_vld)
    `MRDS_ASSERT_NEXT(a_skid_catches, w_s_acc && !w_adv, r_skid_vld)
    `MRDS_ASSERT_NEXT(a_stall_holds, !w_adv, $stable(r_vld))

endmodule

>>> tb/tb_mixed_radix_date_split_core.sv
// Self-checking testbench for the pipelined elapsed-seconds date split core
`timescale 1ns / 1ps

module tb_mixed_radix_date_split_core;
    import mrds_pkg::*;

    localparam int unsigned LATENCY     = 61;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned N_RANDOM    = 1450;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [UNIT_W-1:0] hour;
        logic [UNIT_W-1:0] minute;
        logic [UNIT_W-1:0] second;
    } t_date;

    typedef struct {
        logic [IN_W-1:0] secs;
        logic            has_fixed;
        t_date           fixed;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [OUT_TD_W-1:0]  o_m_axis_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    mixed_radix_date_split_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Unit lengths as written, zero kept
    logic [UNIT_W-1:0] len_spm = RST_SPM, len_mph = RST_MPH, len_hpd = RST_HPD;
    logic [DAY_W-1:0]  len_dpy = RST_DPY;

    t_date       pending_dates[$];
    int unsigned cycles = 0;
    int unsigned errors = 0;
    int unsigned send_idle_pct = 0, recv_idle_pct = 0;
    bit          recv_hold = 1'b0;

    function automatic t_date split_date(logic [IN_W-1:0] secs);
        logic [63:0] spm, mph, hpd, dpy, s_hour, s_day, s_year, t, in_day, in_hour;
        t_date d;
        spm = (len_spm == 0) ? 64'd1 : 64'(len_spm);
        mph = (len_mph == 0) ? 64'd1 : 64'(len_mph);
        hpd = (len_hpd == 0) ? 64'd1 : 64'(len_hpd);
        dpy = (len_dpy == 0) ? 64'd1 : 64'(len_dpy);
        s_hour = spm * mph;
        s_day = s_hour * hpd;
        s_year = s_day * dpy;
        t = 64'(secs) % s_year;
        in_day = t % s_day;
        in_hour = in_day % s_hour;
        d.day = DAY_W'(t / s_day);
        d.hour = UNIT_W'(in_day / s_hour);
        d.minute = UNIT_W'(in_hour / spm);
        d.second = UNIT_W'(t % spm);
        return d;
    endfunction

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL mixed_radix_date_split_core");
            $finish;
        end
    end

    // Receiver: random stall, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_axis_tready <= 1'b0;
        else
            i_m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_date got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.day = o_m_axis_tdata[9:0];
            got.hour = o_m_axis_tdata[17:10];
            got.minute = o_m_axis_tdata[25:18];
            got.second = o_m_axis_tdata[33:26];
            if (pending_dates.size() == 0) begin
                $error("unexpected result %h", o_m_axis_tdata);
                errors++;
            end else begin
                want = pending_dates.pop_front();
                if (got.day !== want.day) begin
                    $error("day_of_year exp %0d got %0d", want.day, got.day); errors++;
                end
                if (got.hour !== want.hour) begin
                    $error("hour_of_day exp %0d got %0d", want.hour, got.hour); errors++;
                end
                if (got.minute !== want.minute) begin
                    $error("minute_of_hour exp %0d got %0d", want.minute, got.minute);
                    errors++;
                end
                if (got.second !== want.second) begin
                    $error("second_of_minute exp %0d got %0d", want.second, got.second);
                    errors++;
                end
                if (o_m_axis_tdata[39:34] !== '0) begin
                    $error("pad exp 0 got %h", o_m_axis_tdata[39:34]); errors++;
                end
            end
        end
    end

    // Offer the request and hold it until tready is sampled high on the rising clock;
    // unless a random idle gap is drawn, valid stays up between requests
    task automatic send_secs(logic [IN_W-1:0] secs, bit has_fixed, t_date fixed);
        t_date want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        want = split_date(secs);
        if (has_fixed && want !== fixed) begin
            $error("table row %h: exp %h predictor %h", secs, fixed, want);
            errors++;
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= secs;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_dates.push_back(has_fixed ? fixed : want);
    endtask

    // Drop valid at the end of a burst
    task automatic end_burst();
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        // Register index comes from address bits 3:2 only
        case (t_reg_idx'(addr[3:2]))
            REG_SPM: len_spm = value[7:0];
            REG_MPH: len_mph = value[7:0];
            REG_HPD: len_hpd = value[7:0];
            REG_DPY: len_dpy = value[9:0];
            default: ;
        endcase
    endtask

    task automatic set_lengths(int spm, int mph, int hpd, int dpy);
        apb_write(4'(REG_SPM) << 2, 32'(spm));
        apb_write(4'(REG_MPH) << 2, 32'(mph));
        apb_write(4'(REG_HPD) << 2, 32'(hpd));
        apb_write(4'(REG_DPY) << 2, 32'(dpy));
    endtask

    function automatic logic [IN_W-1:0] rand_secs();
        case ($urandom_range(5))
            0: return $urandom_range(255);
            1: return 32'hFFFF_FFFF - $urandom_range(255);
            2: return 32'd1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n);
        t_date none;
        none = '0;
        for (int i = 0; i < n; i++) send_secs(rand_secs(), 1'b0, none);
        end_burst();
    endtask

    initial begin
        t_row rows[$];
        t_date none;
        int hold;
        none = '0;
        // Directed table: fixed results at reset lengths for the obvious rows
        rows.push_back('{32'd0, 1'b1, '{10'd0, 8'd0, 8'd0, 8'd0}});
        rows.push_back('{32'd59, 1'b1, '{10'd0, 8'd0, 8'd0, 8'd59}});
        rows.push_back('{32'd60, 1'b1, '{10'd0, 8'd0, 8'd1, 8'd0}});
        rows.push_back('{32'd3599, 1'b1, '{10'd0, 8'd0, 8'd59, 8'd59}});
        rows.push_back('{32'd86399, 1'b1, '{10'd0, 8'd23, 8'd59, 8'd59}});
        rows.push_back('{32'd86400, 1'b1, '{10'd1, 8'd0, 8'd0, 8'd0}});
        rows.push_back('{32'd31535999, 1'b1, '{10'd364, 8'd23, 8'd59, 8'd59}});
        rows.push_back('{32'd31536000, 1'b1, '{10'd0, 8'd0, 8'd0, 8'd0}});
        rows.push_back('{32'hFFFF_FFFF, 1'b0, none});
        rows.push_back('{32'hAAAA_AAAA, 1'b0, none});
        rows.push_back('{32'h5555_5555, 1'b0, none});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_secs(rows[i].secs, rows[i].has_fixed, rows[i].fixed);
        end_burst();
        wait_drained();

        // Zero lengths act as one: everything lands on zero
        set_lengths(0, 0, 0, 0);
        send_secs(32'hFFFF_FFFF, 1'b1, '{10'd0, 8'd0, 8'd0, 8'd0});
        send_secs(32'd12345, 1'b0, none);
        end_burst();
        wait_drained();
        // Largest lengths, and values wider than the registers
        set_lengths(255, 255, 255, 1023);
        send_secs(32'hFFFF_FFFF, 1'b0, none);
        send_secs(32'd0, 1'b0, none);
        end_burst();
        wait_drained();
        apb_write(4'(REG_SPM) << 2, 32'hFFFF_FF07);
        apb_write(4'(REG_DPY) << 2, 32'hFFFF_FC02);
        apb_write(4'd3, 32'd9); // low address bits ignored: lands on seconds per minute
        send_secs(32'hFFFF_FFFF, 1'b0, none);
        send_secs(32'd99999, 1'b0, none);
        end_burst();
        wait_drained();

        // Random phases, idling swapped between them
        set_lengths(RST_SPM, RST_MPH, RST_HPD, RST_DPY);
        send_idle_pct = 9; recv_idle_pct = 69;
        random_phase(N_RANDOM / 4);
        wait_drained();

        set_lengths(1, 1, 1, 1);
        send_idle_pct = 69; recv_idle_pct = 9;
        random_phase(N_RANDOM / 8);
        wait_drained();

        set_lengths($urandom_range(1, 255), $urandom_range(1, 255),
                    $urandom_range(1, 255), $urandom_range(1, 1023));
        random_phase(N_RANDOM / 8);
        wait_drained();

        // Hold the receiver off while the sender keeps offering requests
        send_idle_pct = 0; recv_idle_pct = 0;
        set_lengths(7, 3, 255, 1023);
        fork
            begin
                recv_hold = 1'b1;
                hold = 0;
                while (hold < 200) begin
                    @(posedge i_clk);
                    hold++;
                end
                recv_hold = 1'b0;
            end
            random_phase(120);
        join
        wait_drained();

        set_lengths(255, 255, 255, $urandom_range(1, 1023));
        random_phase(N_RANDOM / 8);
        wait_drained();

        set_lengths($urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 1023));
        random_phase(N_RANDOM / 4);
        wait_drained();

        if (errors == 0)
            $display("PASS mixed_radix_date_split_core");
        else
            $display("FAIL mixed_radix_date_split_core");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/mrds_pkg.sv
rtl/mixed_radix_date_split_core.sv
tb/tb_mixed_radix_date_split_core.sv
